@@ sv/best_fit_block_allocator_unit_macros.svh @@
// assertion macros for the best-fit block allocator
// used by best_fit_block_allocator_unit, expects clk and rst_n in scope
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BFA_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BFA_ASSERT(label, prop, msg)
`define BFA_NEVER(label, expr, msg)
`endif
`endif

@@ sv/bfa_pkg.sv @@
// shared types and codes for the best-fit block allocator
// no dependencies
package bfa_pkg;

  localparam int AMT_W  = 16;
  localparam int ID_W   = 7;
  localparam int STAT_W = 2;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   block_id;
    logic [AMT_W-1:0]  remaining_size;
  } res_t;

endpackage

@@ sv/bfa_if.sv @@
// request and result channels of the best-fit block allocator
// depends on bfa_pkg
interface bfa_in_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [AMT_W-1:0] amount;

  modport source (output valid, output req_type, output amount, input ready);
  modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   block_id;
  logic [AMT_W-1:0]  remaining_size;

  modport source (output valid, output status, output block_id, output remaining_size,
                  input ready);
  modport sink   (input valid, input status, input block_id, input remaining_size,
                  output ready);
endinterface

@@ sv/best_fit_block_allocator_unit.sv @@
// best-fit block allocator: free block table, sequential scan and write-back
// depends on bfa_pkg, bfa_if and best_fit_block_allocator_unit_macros.svh
//
// in_ch carries one request word: req_type 0 appends a free block of size
// amount, req_type 1 allocates amount from the smallest block that fits
// (first one wins a tie). out_ch returns one result word per request:
// status, block_id (1-based, 0 when none) and remaining_size.
// in_ch.ready is high only while the sequencer is idle; one word is worked
// on at a time.
// an add writes its block in ST_ADD, unless the table is full, and loads
// its result in ST_FINISH. an allocate reads the table in ST_SCAN through
// the one memory read port, one block per cycle, with a single compare
// unit, writes back the chosen block, if any, in ST_WRITE and loads its
// result in ST_FINISH, which waits for the output register to free. the
// next request can be taken in the cycle after the load.
// the result sits in an output register, so a new request can be accepted
// while out_ch is stalled; that request then waits for the register to free
// before its own result is loaded.
// reset empties the table (block count to zero) at once; memory contents
// are not cleared since only entries below the count are ever read.
`include "best_fit_block_allocator_unit_macros.svh"

module best_fit_block_allocator_unit
  import bfa_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input logic       clk,
  input logic       rst_n,
  bfa_in_if.sink    in_ch,
  bfa_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // control
  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic                 req_type_r, req_type_nxt;
  logic [SIZE_BITS-1:0] amt_r, amt_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  res_t                 pend_r, pend_nxt;
  res_t                 res_r, res_nxt;

  // memory
  logic [SIZE_BITS-1:0] blk_size_r [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [SIZE_BITS-1:0] mem_wd;

  logic in_fire;
  logic out_free;
  logic issue_more;
  logic table_full;
  logic fits;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign issue_more = rd_idx_r < count_r;
  assign table_full = count_r >= CNT_W'(MAX_BLOCKS);
  // the shared compare unit
  assign fits = (rd_data_r >= amt_r) && (!found_r || (rd_data_r < best_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.req_type == REQ_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: state_nxt = ST_FINISH;
      ST_SCAN: begin
        if (!issue_more && !chk_v_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = rd_idx_r[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_wa      = count_r[IDX_W-1:0];
    mem_wd      = amt_r;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_ADD: mem_we = !table_full;
      ST_SCAN: rd_en = issue_more;
      ST_WRITE: begin
        mem_we = found_r;
        mem_wa = best_idx_r;
        mem_wd = best_r - amt_r;
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    req_type_nxt  = req_type_r;
    amt_nxt       = amt_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (in_fire) begin
      req_type_nxt = in_ch.req_type;
      amt_nxt      = SIZE_BITS'(in_ch.amount);
      rd_idx_nxt   = '0;
      found_nxt    = 1'b0;
    end

    if (state_r == ST_ADD) begin
      if (table_full) begin
        pend_nxt = '{status: STAT_FULL, block_id: '0, remaining_size: '0};
      end else begin
        count_nxt = count_r + CNT_W'(1);
        pend_nxt  = '{status: STAT_OK, block_id: ID_W'(count_r + CNT_W'(1)),
                      remaining_size: AMT_W'(amt_r)};
      end
    end

    if (state_r == ST_SCAN) begin
      if (issue_more) begin
        rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = rd_idx_r[IDX_W-1:0];
      end
      if (chk_v_r && fits) begin
        found_nxt    = 1'b1;
        best_nxt     = rd_data_r;
        best_idx_nxt = chk_idx_r;
      end
    end

    if (state_r == ST_WRITE) begin
      if (found_r) begin
        pend_nxt = '{status: STAT_OK,
                     block_id: ID_W'(CNT_W'(best_idx_r) + CNT_W'(1)),
                     remaining_size: AMT_W'(mem_wd)};
      end else begin
        pend_nxt = '{status: STAT_NOFIT, block_id: '0, remaining_size: '0};
      end
    end

    if (state_r == ST_FINISH && out_free) begin
      res_nxt       = pend_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_v_r     <= chk_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    amt_r      <= amt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    res_r      <= res_nxt;
  end

  // block size table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_size_r[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= blk_size_r[rd_addr];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.block_id       = res_r.block_id;
  assign out_ch.remaining_size = res_r.remaining_size;

  `BFA_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_BLOCKS), "block count above table size")
  `BFA_ASSERT(a_we_state, mem_we |-> (state_r == ST_ADD || state_r == ST_WRITE),
              "table written outside add or write-back")
  `BFA_ASSERT(a_best_fits, (found_r && req_type_r == REQ_ALLOC) |-> (best_r >= amt_r),
              "chosen block smaller than request")
  `BFA_NEVER(a_scan_add, state_r == ST_SCAN && req_type_r == REQ_ADD,
             "scan running for an add request")
  `BFA_ASSERT(a_load_finish, $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH),
              "result loaded outside finish")

endmodule
